### rtl/core/prp_pkg.sv
package prp_pkg;

   localparam int PAGE_FIELD_BITS = 8;
   localparam int TOTAL_BITS = 32;
   localparam int MODE_BITS = 3;
   localparam int FRAMES_BITS = 4;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS = 8;

   localparam int DEF_MAX_FRAMES = 8;
   localparam int DEF_PAGE_BITS = 8;
   localparam int DEF_COUNT_BITS = 16;

   localparam logic [FRAMES_BITS-1:0] FRAMES_RESET = 4'd3;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_POLICY_MODE = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAMES_IN_USE = 2'd1;

   localparam logic [MODE_BITS-1:0] MODE_FIFO = 3'd0;
   localparam logic [MODE_BITS-1:0] MODE_LRU = 3'd1;
   localparam logic [MODE_BITS-1:0] MODE_LFU_FIFO = 3'd2;
   localparam logic [MODE_BITS-1:0] MODE_MFU_FIFO = 3'd3;
   localparam logic [MODE_BITS-1:0] MODE_LFU_LRU = 3'd4;
   localparam logic [MODE_BITS-1:0] MODE_MFU_LRU = 3'd5;

   typedef struct packed {
      logic flush;
      logic load;
      logic shift;
      logic bump;
   } cell_ctl_type;

endpackage

### rtl/core/prp_if.sv
interface prp_req_if;
   logic valid;
   logic ready;
   logic [prp_pkg::PAGE_FIELD_BITS-1:0] page_number;
   modport source (output valid, output page_number, input ready);
   modport sink (input valid, input page_number, output ready);
endinterface

interface prp_rsp_if;
   logic valid;
   logic ready;
   logic hit;
   logic replaced;
   logic [prp_pkg::PAGE_FIELD_BITS-1:0] evicted_page;
   logic [prp_pkg::TOTAL_BITS-1:0] fault_total;
   logic [prp_pkg::TOTAL_BITS-1:0] replace_total;
   modport source (output valid, output hit, output replaced, output evicted_page,
                   output fault_total, output replace_total, input ready);
   modport sink (input valid, input hit, input replaced, input evicted_page,
                 input fault_total, input replace_total, output ready);
endinterface

interface prp_csr_if;
   logic valid;
   logic ready;
   logic [prp_pkg::CSR_INDEX_BITS-1:0] index;
   logic [prp_pkg::CSR_DATA_BITS-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

### rtl/core/prp_cell.sv
module prp_cell #(
   parameter int PAGE_BITS = prp_pkg::DEF_PAGE_BITS,
   parameter int COUNT_BITS = prp_pkg::DEF_COUNT_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  prp_pkg::cell_ctl_type  ctl,
   input  logic                   prev_valid,
   input  logic [PAGE_BITS-1:0]   prev_page,
   input  logic [COUNT_BITS-1:0]  prev_count,
   input  logic [PAGE_BITS-1:0]   load_page,
   input  logic [COUNT_BITS-1:0]  load_count,
   output logic                   valid,
   output logic [PAGE_BITS-1:0]   page,
   output logic [COUNT_BITS-1:0]  count
);

   logic                  valid_ff, valid_in;
   logic [PAGE_BITS-1:0]  page_ff, page_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;

   always_comb begin
      valid_in = valid_ff;
      page_in = page_ff;
      count_in = count_ff;
      priority if (ctl.flush) begin
         valid_in = 1'b0;
      end else if (ctl.load) begin
         valid_in = 1'b1;
         page_in = load_page;
         count_in = load_count;
      end else if (ctl.shift) begin
         valid_in = prev_valid;
         page_in = prev_page;
         count_in = prev_count;
      end else if (ctl.bump && count_ff != '1) begin
         count_in = count_ff + COUNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      page_ff <= page_in;
      count_ff <= count_in;
   end

   assign valid = valid_ff;
   assign page = page_ff;
   assign count = count_ff;

endmodule

### rtl/core/page_replacement_policy_unit.sv
// page replacement policy unit
// req_chan: one page reference per transfer (low PAGE_BITS of page_number used)
// rsp_chan: one result per reference: hit, replaced, evicted page and the
//    saturating fault and replace totals including this reference
// csr_chan: always ready; index 0 policy mode, index 1 frames in use; writing
//    the frame count invalidates every slot, totals are kept
// the slots form a row of cells, newest at slot 0; on a miss or an lru hit the
//    cells in front of the victim each take their neighbor's contents together
// the request passes the look and apply states and the result is registered in
//    apply; on a miss in the lfu and mfu modes with all slots in use a search
//    state first walks the slots from the back, one per cycle, for the victim
// one reference is taken at a time: the request channel is ready again once the
//    result sits in the output register; a stalled receiver holds the next result
//    back in the apply state
// reset: mode fifo, 3 frames, all slots invalid, totals zero, no result pending
module page_replacement_policy_unit #(
   parameter int MAX_FRAMES = prp_pkg::DEF_MAX_FRAMES,
   parameter int PAGE_BITS = prp_pkg::DEF_PAGE_BITS,
   parameter int COUNT_BITS = prp_pkg::DEF_COUNT_BITS
) (
   input  logic          clock,
   input  logic          reset,
   prp_req_if.sink       req_chan,
   prp_rsp_if.source     rsp_chan,
   prp_csr_if.sink       csr_chan
);

   localparam int IDX_BITS = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
   localparam int EXT_BITS = (PAGE_BITS > prp_pkg::PAGE_FIELD_BITS) ?
                             PAGE_BITS : prp_pkg::PAGE_FIELD_BITS;
   localparam int TB = prp_pkg::TOTAL_BITS;

   typedef enum logic [1:0] {S_IDLE, S_LOOK, S_SEARCH, S_APPLY} state_type;

   state_type                          state_ff;
   logic [prp_pkg::MODE_BITS-1:0]      mode_ff;
   logic [prp_pkg::FRAMES_BITS-1:0]    frames_ff;
   logic [PAGE_BITS-1:0]               pg_ff;
   logic                               hit_ff;
   logic                               full_ff;
   logic [IDX_BITS-1:0]                pos_ff;
   logic [IDX_BITS-1:0]                idx_ff;
   logic [COUNT_BITS-1:0]              best_ff;
   logic [TB-1:0]                      fault_ff, fault_in;
   logic [TB-1:0]                      replace_ff, replace_in;
   logic                               rsp_valid_ff;
   logic                               rsp_hit_ff;
   logic                               rsp_replaced_ff;
   logic [prp_pkg::PAGE_FIELD_BITS-1:0] rsp_evicted_ff;
   logic [TB-1:0]                      rsp_fault_ff;
   logic [TB-1:0]                      rsp_replace_ff;

   logic                    counted, lru_order, most;
   logic [IDX_BITS-1:0]     last_idx;
   logic [EXT_BITS-1:0]     req_wide;
   logic [PAGE_BITS-1:0]    req_page;
   logic [MAX_FRAMES-1:0]   valid_vec;
   logic [MAX_FRAMES-1:0]   hit_vec;
   logic [PAGE_BITS-1:0]    cell_page [MAX_FRAMES];
   logic [COUNT_BITS-1:0]   cell_count [MAX_FRAMES];
   prp_pkg::cell_ctl_type   cell_ctl [MAX_FRAMES];
   logic                    any_hit;
   logic [IDX_BITS-1:0]     hit_at;
   logic                    out_free, apply_go, reorder;
   logic                    flush_slots;
   logic [COUNT_BITS-1:0]   pos_count, load_count, scan_count;
   logic                    better;
   logic                    replaced;
   logic [EXT_BITS-1:0]     evict_wide;

   // mode decode, unused codes behave as fifo
   always_comb begin
      counted = 1'b0;
      lru_order = 1'b0;
      most = 1'b0;
      unique case (mode_ff)
         prp_pkg::MODE_LRU: begin
            lru_order = 1'b1;
         end
         prp_pkg::MODE_LFU_FIFO: begin
            counted = 1'b1;
         end
         prp_pkg::MODE_MFU_FIFO: begin
            counted = 1'b1;
            most = 1'b1;
         end
         prp_pkg::MODE_LFU_LRU: begin
            counted = 1'b1;
            lru_order = 1'b1;
         end
         prp_pkg::MODE_MFU_LRU: begin
            counted = 1'b1;
            lru_order = 1'b1;
            most = 1'b1;
         end
         default: begin
            counted = 1'b0;
         end
      endcase
   end

   always_comb begin
      priority if (frames_ff == '0) begin
         last_idx = '0;
      end else if (32'(frames_ff) > 32'(MAX_FRAMES)) begin
         last_idx = IDX_BITS'(MAX_FRAMES - 1);
      end else begin
         last_idx = IDX_BITS'(32'(frames_ff) - 32'd1);
      end
   end

   assign req_wide = EXT_BITS'(req_chan.page_number);
   assign req_page = req_wide[PAGE_BITS-1:0];

   assign flush_slots = csr_chan.valid && csr_chan.index == prp_pkg::CSR_FRAMES_IN_USE;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign apply_go = state_ff == S_APPLY && out_free;
   assign reorder = !hit_ff || lru_order;

   assign pos_count = cell_count[pos_ff];
   assign scan_count = cell_count[idx_ff];
   assign better = most ? (scan_count > best_ff) : (scan_count < best_ff);

   always_comb begin
      if (!hit_ff) begin
         load_count = COUNT_BITS'(1);
      end else if (counted && pos_count != '1) begin
         load_count = pos_count + COUNT_BITS'(1);
      end else begin
         load_count = pos_count;
      end
   end

   // slot row
   for (genvar i = 0; i < MAX_FRAMES; i++) begin : g_cell
      logic                  prev_valid;
      logic [PAGE_BITS-1:0]  prev_page;
      logic [COUNT_BITS-1:0] prev_count;

      if (i == 0) begin : g_head
         assign prev_valid = 1'b0;
         assign prev_page = '0;
         assign prev_count = '0;
      end else begin : g_body
         assign prev_valid = valid_vec[i-1];
         assign prev_page = cell_page[i-1];
         assign prev_count = cell_count[i-1];
      end

      assign cell_ctl[i].flush = flush_slots;
      assign cell_ctl[i].load = apply_go && reorder && i == 0;
      assign cell_ctl[i].shift = apply_go && reorder && i != 0 &&
                                 IDX_BITS'(i) <= pos_ff;
      assign cell_ctl[i].bump = apply_go && hit_ff && !lru_order && counted &&
                                IDX_BITS'(i) == pos_ff;

      assign hit_vec[i] = valid_vec[i] && cell_page[i] == pg_ff &&
                          IDX_BITS'(i) <= last_idx;

      prp_cell #(
         .PAGE_BITS  (PAGE_BITS),
         .COUNT_BITS (COUNT_BITS)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (cell_ctl[i]),
         .prev_valid (prev_valid),
         .prev_page  (prev_page),
         .prev_count (prev_count),
         .load_page  (pg_ff),
         .load_count (load_count),
         .valid      (valid_vec[i]),
         .page       (cell_page[i]),
         .count      (cell_count[i])
      );
   end

   // first matching slot
   always_comb begin
      hit_at = '0;
      for (int i = MAX_FRAMES - 1; i >= 0; i--) begin
         if (hit_vec[i]) begin
            hit_at = IDX_BITS'(i);
         end
      end
   end
   assign any_hit = |hit_vec;

   assign replaced = !hit_ff && full_ff;
   assign evict_wide = EXT_BITS'(cell_page[pos_ff]);
   assign fault_in = (hit_ff || fault_ff == '1) ? fault_ff : fault_ff + TB'(1);
   assign replace_in = (!replaced || replace_ff == '1) ? replace_ff :
                       replace_ff + TB'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         mode_ff <= prp_pkg::MODE_FIFO;
         frames_ff <= prp_pkg::FRAMES_RESET;
         fault_ff <= '0;
         replace_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_chan.valid && csr_chan.index == prp_pkg::CSR_POLICY_MODE) begin
            mode_ff <= csr_chan.data[prp_pkg::MODE_BITS-1:0];
         end
         if (flush_slots) begin
            frames_ff <= csr_chan.data[prp_pkg::FRAMES_BITS-1:0];
         end
         if (rsp_chan.ready && !apply_go) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_chan.valid) begin
                  pg_ff <= req_page;
                  state_ff <= S_LOOK;
               end
            end
            S_LOOK: begin
               hit_ff <= any_hit;
               full_ff <= valid_vec[last_idx];
               best_ff <= cell_count[last_idx];
               idx_ff <= last_idx - IDX_BITS'(1);
               if (any_hit) begin
                  pos_ff <= hit_at;
                  state_ff <= S_APPLY;
               end else begin
                  pos_ff <= last_idx;
                  if (valid_vec[last_idx] && counted && last_idx != '0) begin
                     state_ff <= S_SEARCH;
                  end else begin
                     state_ff <= S_APPLY;
                  end
               end
            end
            S_SEARCH: begin
               if (better) begin
                  best_ff <= scan_count;
                  pos_ff <= idx_ff;
               end
               idx_ff <= idx_ff - IDX_BITS'(1);
               if (idx_ff == '0) begin
                  state_ff <= S_APPLY;
               end
            end
            S_APPLY: begin
               if (out_free) begin
                  fault_ff <= fault_in;
                  replace_ff <= replace_in;
                  rsp_valid_ff <= 1'b1;
                  rsp_hit_ff <= hit_ff;
                  rsp_replaced_ff <= replaced;
                  rsp_evicted_ff <= replaced ? evict_wide[prp_pkg::PAGE_FIELD_BITS-1:0] : '0;
                  rsp_fault_ff <= fault_in;
                  rsp_replace_ff <= replace_in;
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_chan.ready = state_ff == S_IDLE;
   assign csr_chan.ready = 1'b1;
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.hit = rsp_hit_ff;
   assign rsp_chan.replaced = rsp_replaced_ff;
   assign rsp_chan.evicted_page = rsp_evicted_ff;
   assign rsp_chan.fault_total = rsp_fault_ff;
   assign rsp_chan.replace_total = rsp_replace_ff;

`ifndef SYNTHESIS
   // valid slots always form a prefix of the row
   assert property (@(posedge clock) disable iff (reset)
      $onehot({1'b0, valid_vec} + (MAX_FRAMES + 1)'(1)))
      else $error("slot valid bits are not a prefix");

   // a page is resident in at most one slot
   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_LOOK |-> $onehot0(hit_vec))
      else $error("page found in more than one slot");

   // the fault total never goes down
   assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> fault_ff >= $past(fault_ff))
      else $error("fault total decreased");

   // a hit never reports a replacement
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_hit_ff && rsp_replaced_ff))
      else $error("hit with replacement");
`endif

endmodule
